FILE: hw/rtl/linear_resampler_16bit_assert.svh
// assertion macros shared by the resampler checker
`ifndef LINEAR_RESAMPLER_16BIT_ASSERT_SVH
`define LINEAR_RESAMPLER_16BIT_ASSERT_SVH

// implication checked on the following edge, off while reset is held
`define LRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication checked on the following edge, also during reset
`define LRS_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lrs_pkg.sv
// shared constants, types and control structs of the linear resampler
package lrs_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_UPSAMPLE = 16;
    localparam int SAMPLE_W     = 16;
    localparam int STEP_W       = 21;

    // accumulator holds below one position plus one step
    localparam int ACC_W  = ((STEP_W > FRAC_BITS) ? STEP_W : FRAC_BITS) + 1;
    localparam int CNT_W  = $clog2(MAX_UPSAMPLE + 1);
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = FRAC_BITS + 1 + DIFF_W;
    localparam int V_W    = FRAC_BITS + SAMPLE_W + 3;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64'd1 << FRAC_BITS);
    localparam logic [ACC_W-1:0]  ACC_ONE    = ACC_W'(64'd1 << FRAC_BITS);
    localparam logic [V_W-1:0]    RND_BIAS   = V_W'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(MAX_UPSAMPLE);
    localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(MAX_UPSAMPLE - 1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [STEP_W-1:0]          t_step;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the incoming word
        logic issue;    // start one interpolation, advance the phase
        logic last;     // the issued output closes this input's run
        logic finish;   // update previous sample and phase, end the item
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic have_prev;
        logic acc_below_one;
        logic next_below_one;
        logic pipe_en;
    } t_dp_status;

endpackage

FILE: hw/rtl/lrs_if.sv
// valid/ready stream interfaces for input and output words
interface lrs_in_if;
    logic                   valid;
    logic                   ready;
    logic signed [15:0]     in_sample;
    logic                   end_of_stream;

    modport source (output valid, output in_sample, output end_of_stream, input ready);
    modport sink   (input valid, input in_sample, input end_of_stream, output ready);
endinterface

interface lrs_out_if;
    logic                   valid;
    logic                   ready;
    logic signed [15:0]     out_sample;
    logic                   last_of_run;

    modport source (output valid, output out_sample, output last_of_run, input ready);
    modport sink   (input valid, input out_sample, input last_of_run, output ready);
endinterface

FILE: hw/rtl/lrs_dp.sv
// datapath: step register, sample and phase state, interpolation pipeline
module lrs_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  lrs_pkg::t_step        i_cfg_wdata,
    input  lrs_pkg::t_sample      i_in_sample,
    input  logic                  i_in_eos,
    input  lrs_pkg::t_dp_cmd      i_cmd,
    output lrs_pkg::t_dp_status   o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output lrs_pkg::t_sample      o_out_sample,
    output logic                  o_out_last
);
    import lrs_pkg::*;

    t_step                      r_step;
    t_sample                    r_b;
    logic                       r_eos;
    t_sample                    r_prev,      n_prev;
    logic                       r_have_prev, n_have_prev;
    logic [ACC_W-1:0]           r_acc,       n_acc;
    logic                       r_p_vld;
    logic signed [PROD_W-1:0]   r_p_prod;
    t_sample                    r_p_a;
    logic                       r_p_last;
    logic                       r_o_vld;
    t_sample                    r_o_sample;
    logic                       r_o_last;

    logic [ACC_W-1:0]           w_acc_step;
    logic signed [FRAC_BITS:0]  w_frac;
    logic signed [DIFF_W-1:0]   w_diff;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [V_W-1:0]      w_v;
    logic signed [V_W-1:0]      w_bias;
    logic signed [V_W-1:0]      w_rnd;
    logic                       w_pipe_en;

    // phase arithmetic
    assign w_acc_step = r_acc + ACC_W'(r_step);
    assign w_pipe_en  = !r_o_vld || i_out_ready;

    assign o_status.have_prev      = r_have_prev;
    assign o_status.acc_below_one  = (r_acc < ACC_ONE);
    assign o_status.next_below_one = (w_acc_step < ACC_ONE);
    assign o_status.pipe_en        = w_pipe_en;

    // step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (i_cfg_we) begin
            r_step <= i_cfg_wdata;
        end
    end

    // captured input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_b   <= i_in_sample;
            r_eos <= i_in_eos;
        end
    end

    // state update: phase advance on issue, previous sample and phase at the end of an item
    always_comb begin
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_acc       = r_acc;
        if (i_cmd.issue) begin
            n_acc = w_acc_step;
        end
        if (i_cmd.finish) begin
            if (r_eos) begin
                n_prev      = '0;
                n_have_prev = 1'b0;
                n_acc       = '0;
            end else begin
                n_prev      = r_b;
                n_have_prev = 1'b1;
                if (!r_have_prev || (r_acc < ACC_ONE)) begin
                    n_acc = '0;
                end else begin
                    n_acc = r_acc - ACC_ONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_acc       <= '0;
        end else begin
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
            r_acc       <= n_acc;
        end
    end

    // stage one: frac * (b - a)
    assign w_frac = $signed({1'b0, r_acc[FRAC_BITS-1:0]});
    assign w_diff = DIFF_W'(r_b) - DIFF_W'(r_prev);
    assign w_prod = PROD_W'(w_frac) * PROD_W'(w_diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_pipe_en) begin
            r_p_vld <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pipe_en && i_cmd.issue) begin
            r_p_prod <= w_prod;
            r_p_a    <= r_prev;
            r_p_last <= i_cmd.last;
        end
    end

    // stage two: add a, truncate toward zero
    assign w_v    = (V_W'(r_p_a) <<< FRAC_BITS) + V_W'(r_p_prod);
    assign w_bias = w_v[V_W-1] ? $signed(RND_BIAS) : '0;
    assign w_rnd  = (w_v + w_bias) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_pipe_en) begin
            r_o_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pipe_en && r_p_vld) begin
            r_o_sample <= w_rnd[SAMPLE_W-1:0];
            r_o_last   <= r_p_last;
        end
    end

    assign o_out_valid  = r_o_vld;
    assign o_out_sample = r_o_sample;
    assign o_out_last   = r_o_last;

endmodule

FILE: hw/rtl/lrs_ctrl.sv
// controller: accepts a word, walks the output positions of its interval
module lrs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lrs_pkg::t_dp_status   i_status,
    output lrs_pkg::t_dp_cmd      o_cmd
);
    import lrs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_status.have_prev) begin
                    // first word of a stream only gets stored
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_status.acc_below_one && (r_cnt < CNT_MAX)) begin
                    if (i_status.pipe_en) begin
                        o_cmd.issue = 1'b1;
                        o_cmd.last  = !i_status.next_below_one || (r_cnt == CNT_LAST);
                        n_cnt       = r_cnt + 1'b1;
                    end
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: hw/rtl/linear_resampler_16bit.sv
// top level of the linear interpolation resampler
//
//   port          dir   word fields                   handshake
//   i_in          in    in_sample, end_of_stream      valid/ready
//   o_out         out   out_sample, last_of_run       valid/ready
//   i_cfg_we/..   in    phase_step (21 bits)          write enable only
//
// an input word is accepted, then gets one issue per output (up to 16 outputs)
// and a final update; the controller issues one interpolation per cycle, unless
// the output stalls, into a two-stage multiply/round pipeline.
// an issued interpolation passes the product and output registers; a stalled output freezes the pipeline.
// reset is synchronous; it clears the state and sets phase_step to 1.0.
module linear_resampler_16bit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lrs_in_if.sink               i_in,
    lrs_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  lrs_pkg::t_step       i_cfg_wdata
);
    import lrs_pkg::*;

    t_dp_cmd     w_cmd;
    t_dp_status  w_status;
    logic        w_in_ready;

    assign i_in.ready = w_in_ready;

    // sequencer
    lrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // arithmetic and state
    lrs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_sample  (i_in.in_sample),
        .i_in_eos     (i_in.end_of_stream),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_sample (o_out.out_sample),
        .o_out_last   (o_out.last_of_run)
    );

endmodule

FILE: hw/rtl/lrs_checker.sv
// port-level assertions for the resampler, bound to the top level
`include "linear_resampler_16bit_assert.svh"

module lrs_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic signed [15:0]   i_out_sample,
    input  logic                 i_out_last
);

    // a stalled output word stays offered
    `LRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "output word dropped while stalled")

    // a stalled output word keeps its payload
    `LRS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_sample) && $stable(i_out_last), "output word changed while stalled")

    // one word at a time: the block is busy right after an accept
    `LRS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input accepted on back-to-back cycles")

    // reset empties the output stage
    `LRS_ASSERT_ALWAYS_NEXT(a_reset_clears, i_clk, !i_rst_n, !i_out_valid, "output valid after reset")

endmodule

bind linear_resampler_16bit lrs_checker u_lrs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.out_sample),
    .i_out_last   (o_out.last_of_run)
);

FILE: tb/sv/tb_top.sv
// testbench for linear_resampler_16bit: predicted interpolation vs. dut output words
`timescale 1ns / 1ps

module tb_top;
    import lrs_pkg::*;

    localparam logic [31:0] ONE_POS         = 32'd1 << FRAC_BITS;
    localparam int          SETTLE_CYCLES   = 24;
    localparam int          RAND_PHASES     = 12;
    localparam int          WORDS_PER_PHASE = 37;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_SILENT,
        CHK_TYPED
    } t_check;

    typedef struct packed {
        logic    wr;
        t_step   step;
        t_sample smp;
        logic    eos;
        t_check  chk;
        t_sample y;
    } t_dir_row;

    typedef struct packed {
        t_sample y;
        logic    last;
    } t_out_word;

    // directed rows: optional step write, then one input word
    localparam int DIR_COUNT = 25;
    localparam t_dir_row DIRECTED [DIR_COUNT] = '{
        // reset step of 1.0, one output per interval
        '{1'b0, 21'h000000, 16'sd100,    1'b0, CHK_SILENT, 16'sd0},
        '{1'b0, 21'h000000, 16'sd200,    1'b0, CHK_TYPED,  16'sd100},
        '{1'b0, 21'h000000, 16'sd32767,  1'b0, CHK_TYPED,  16'sd200},
        '{1'b0, 21'h000000, 16'sh8000,   1'b0, CHK_TYPED,  16'sd32767},
        '{1'b0, 21'h000000, 16'sd32767,  1'b1, CHK_TYPED,  16'sh8000},
        // stream of a single sample
        '{1'b0, 21'h000000, -16'sd5,     1'b1, CHK_SILENT, 16'sd0},
        // step 0.5, truncation toward zero on both signs
        '{1'b1, 21'h008000, 16'sd0,      1'b0, CHK_SILENT, 16'sd0},
        '{1'b0, 21'h000000, 16'sd3,      1'b0, CHK_PREDICT, 16'sd0},
        '{1'b0, 21'h000000, -16'sd3,     1'b0, CHK_PREDICT, 16'sd0},
        '{1'b0, 21'h000000, -16'sd4,     1'b0, CHK_PREDICT, 16'sd0},
        // zero step: output count capped
        '{1'b1, 21'h000000, 16'sd7,      1'b0, CHK_PREDICT, 16'sd0},
        '{1'b0, 21'h000000, 16'sd9,      1'b1, CHK_PREDICT, 16'sd0},
        // largest step: downsampling skips
        '{1'b1, 21'h1FFFFF, 16'sd1,      1'b0, CHK_SILENT, 16'sd0},
        '{1'b0, 21'h000000, 16'sd2,      1'b0, CHK_TYPED,  16'sd1},
        '{1'b0, 21'h000000, 16'sd3,      1'b0, CHK_SILENT, 16'sd0},
        '{1'b0, 21'h000000, 16'sd4,      1'b1, CHK_SILENT, 16'sd0},
        // step 1/16: exactly the full output count, full-scale swing
        '{1'b1, 21'h001000, 16'sh8000,   1'b0, CHK_SILENT, 16'sd0},
        '{1'b0, 21'h000000, 16'sd32767,  1'b0, CHK_PREDICT, 16'sd0},
        '{1'b0, 21'h000000, 16'sh8000,   1'b1, CHK_PREDICT, 16'sd0},
        // step just below 1/16: tail positions dropped
        '{1'b1, 21'h000FFF, 16'sd1000,   1'b0, CHK_SILENT, 16'sd0},
        '{1'b0, 21'h000000, -16'sd1000,  1'b0, CHK_PREDICT, 16'sd0},
        '{1'b0, 21'h000000, 16'sd0,      1'b1, CHK_PREDICT, 16'sd0},
        // step 16.0
        '{1'b1, 21'h100000, 16'sd5,      1'b0, CHK_SILENT, 16'sd0},
        '{1'b0, 21'h000000, 16'sd6,      1'b0, CHK_TYPED,  16'sd5},
        '{1'b0, 21'h000000, 16'sd7,      1'b1, CHK_SILENT, 16'sd0}
    };

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_cfg_we;
    t_step  i_cfg_wdata;

    lrs_in_if  in_if ();
    lrs_out_if out_if ();

    linear_resampler_16bit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // predictor state
    t_step       step_reg    = STEP_RESET;
    t_sample     hist_sample = '0;
    logic        stream_open = 1'b0;
    logic [31:0] pos_acc     = '0;

    t_out_word   interval_outputs [$];
    t_out_word   due_outputs [$];
    int          mismatch_count = 0;
    bit          sender_quiet = 1'b0;
    bit          sink_quiet = 1'b0;

    // clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 70)
            return 0;
        if (r < 93)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // a + frac*(b-a), exact, truncated toward zero
    function automatic t_sample lerp_sample(input t_sample a, input t_sample b,
                                            input logic [31:0] frac);
        longint v;
        longint mag;
        v = longint'(a) * longint'(ONE_POS) + longint'(frac) * (longint'(b) - longint'(a));
        if (v >= 0)
            mag = v >>> FRAC_BITS;
        else
            mag = -((-v) >>> FRAC_BITS);
        return t_sample'(mag);
    endfunction

    // outputs of the interval closed by one input word
    task automatic interpolate_interval(input t_sample s, input logic e);
        int        cnt;
        t_out_word w;
        interval_outputs.delete();
        cnt = 0;
        if (!stream_open) begin
            hist_sample = s;
            stream_open = 1'b1;
            pos_acc     = '0;
        end else begin
            while (pos_acc < ONE_POS && cnt < MAX_UPSAMPLE) begin
                w.y    = lerp_sample(hist_sample, s, pos_acc);
                w.last = 1'b0;
                interval_outputs.push_back(w);
                cnt++;
                pos_acc += 32'(step_reg);
            end
            if (pos_acc < ONE_POS)
                pos_acc = '0;
            else
                pos_acc -= ONE_POS;
            hist_sample = s;
            if (cnt > 0) begin
                w = interval_outputs.pop_back();
                w.last = 1'b1;
                interval_outputs.push_back(w);
            end
        end
        if (e) begin
            hist_sample = '0;
            stream_open = 1'b0;
            pos_acc     = '0;
        end
    endtask

    // wait until every expected word is out and the block has settled
    task automatic drain_outputs();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (due_outputs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write while the block is idle
    task automatic load_step(input t_step v);
        drain_outputs();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        step_reg = v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= t_step'($urandom);
    endtask

    // drive one input word, predict on acceptance, then idle for the given gap, if any
    task automatic send_word(input t_sample s, input logic e, input t_check chk,
                             input t_sample y_typed, input int gap);
        t_out_word w;
        @(negedge i_clk);
        in_if.valid         <= 1'b1;
        in_if.in_sample     <= s;
        in_if.end_of_stream <= e;
        do @(posedge i_clk); while (!in_if.ready);
        interpolate_interval(s, e);
        case (chk)
            CHK_PREDICT: begin
                foreach (interval_outputs[i])
                    due_outputs.push_back(interval_outputs[i]);
            end
            CHK_TYPED: begin
                w.y    = y_typed;
                w.last = 1'b1;
                due_outputs.push_back(w);
            end
            default: ;
        endcase
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid         <= 1'b0;
            in_if.in_sample     <= t_sample'($urandom);
            in_if.end_of_stream <= 1'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // output word check against the oldest expectation
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (due_outputs.size() == 0) begin
                note_mismatch($sformatf("unexpected word, out_sample %0d last_of_run %0b",
                                        out_if.out_sample, out_if.last_of_run));
            end else begin
                want = due_outputs.pop_front();
                if (out_if.out_sample !== want.y)
                    note_mismatch($sformatf("out_sample got %0d want %0d",
                                            out_if.out_sample, want.y));
                if (out_if.last_of_run !== want.last)
                    note_mismatch($sformatf("last_of_run got %0b want %0b",
                                            out_if.last_of_run, want.last));
            end
        end
    end

    // output side back-pressure
    initial begin
        int stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                stall_left = pick_gap(sink_quiet);
            end
            if ($urandom_range(0, 299) == 0)
                sink_quiet = ($urandom_range(0, 3) == 0);
        end
    end

    // stimulus
    initial begin
        t_step   step_pick;
        t_sample smp;
        logic    eos;
        int      style;
        int      walk;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        in_if.valid         = 1'b0;
        in_if.in_sample     = '0;
        in_if.end_of_stream = 1'b0;
        smp   = '0;
        eos   = 1'b1;
        style = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].wr)
                load_step(DIRECTED[i].step);
            send_word(DIRECTED[i].smp, DIRECTED[i].eos, DIRECTED[i].chk, DIRECTED[i].y,
                      pick_gap(1'b0));
        end

        // random phases, one step setting each
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 6)
                0: step_pick = t_step'($urandom_range(4096, 1048576));
                1: step_pick = t_step'($urandom_range(4096, 65536));
                2: step_pick = t_step'($urandom_range(65536, 1048576));
                3: begin
                    case ($urandom_range(0, 3))
                        0: step_pick = '0;
                        1: step_pick = t_step'(4096);
                        2: step_pick = t_step'(1048576);
                        default: step_pick = '1;
                    endcase
                end
                4: step_pick = t_step'($urandom);
                default: step_pick = t_step'($urandom_range(1, 4095));
            endcase
            load_step(step_pick);
            sender_quiet = (ph % 3 == 2);
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                // new stream picks its flavor
                if (eos)
                    style = int'($urandom_range(0, 9));
                case (style)
                    5, 6, 7: begin
                        walk = int'(smp) + int'($urandom_range(0, 256)) - 128;
                        if (walk > 32767)
                            walk = 32767;
                        if (walk < -32768)
                            walk = -32768;
                        smp = t_sample'(walk);
                    end
                    8: smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    default: smp = t_sample'($urandom);
                endcase
                if (style == 9)
                    eos = ($urandom_range(0, 2) == 0);
                else
                    eos = ($urandom_range(0, 11) == 0);
                send_word(smp, eos, CHK_PREDICT, '0, pick_gap(sender_quiet));
            end
        end

        drain_outputs();
        if (mismatch_count == 0)
            $display("linear_resampler_16bit: match");
        else
            $display("linear_resampler_16bit: mismatch");
        $finish;
    end

    // run limit
    initial begin
        #5000000;
        $display("linear_resampler_16bit: mismatch");
        $finish;
    end

endmodule
